// ===== hdl/vpd_pkg.sv =====
// Shared types, constants and a helper function for the valve PID drive.
package vpd_pkg;

	localparam int VALVE_W   = 12;
	localparam int INTEG_W   = 24;
	localparam int MUL_W     = 14;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int QUOT_W    = 11;
	localparam int DEN_W     = 11;

	localparam logic [VALVE_W-1:0] VALVE_MID  = 12'd2048;
	localparam logic [VALVE_W-1:0] LO_STD     = 12'd450;
	localparam logic [VALVE_W-1:0] HI_STD     = 12'd3645;
	localparam logic [VALVE_W-1:0] LO_NARROW  = 12'd1064;
	localparam logic [VALVE_W-1:0] HI_NARROW  = 12'd3031;
	localparam logic [7:0]         PARK_ANGLE = 8'd180;
	localparam int                 PID_LIMIT  = 2048;

	localparam logic [1:0] DIR_RAISE = 2'd0;
	localparam logic [1:0] DIR_LOWER = 2'd1;
	localparam logic [1:0] DIR_HOLD  = 2'd2;
	localparam logic [1:0] DIR_NONE  = 2'd3;
	localparam logic [1:0] KIND_NARROW = 2'd2;

	typedef enum logic [2:0] {
		REG_KP        = 3'd0,
		REG_KI        = 3'd1,
		REG_END_ANGLE = 3'd2,
		REG_RET_DB    = 3'd3,
		REG_EXT_DB    = 3'd4,
		REG_KIND      = 3'd5
	} vpd_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_SUM,
		ST_MUL_MAP,
		ST_CODE,
		ST_MUL_EXT,
		ST_DIV_EXT,
		ST_WAIT_EXT,
		ST_MUL_RET,
		ST_DIV_RET,
		ST_WAIT_RET,
		ST_DONE
	} vpd_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [PROD_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} vpd_div_req_t;

	// Signed divide by 2048 with truncation toward zero.
	function automatic logic signed [16:0] sdiv2048(input logic signed [PROD_W-1:0] n);
		logic [PROD_W-1:0] mag;
		logic [16:0]       q;
		mag = n[PROD_W-1] ? PROD_W'(-n) : PROD_W'(n);
		q   = mag[27:11];
		return n[PROD_W-1] ? $signed(-q) : $signed(q);
	endfunction

endpackage

// ===== hdl/valve_pid_drive_top.sv =====
// Top level of the valve PID drive: sequencer, state and stream ports.
// An engaged item with a full angle update runs the PID steps, the code step and two
// multiply-divide angle passes; a small cut ends after the code step, a disengaged item
// goes straight to done, and the next request waits for idle. One shared multiplier and a
// divider serve every step; one item at a time, and a result not taken holds the sequencer.
// Reset parks both held angles at 180, clears the errors and the integral, loads gain defaults.
module valve_pid_drive_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cut_direction[1:0], cut_amount[9:2], auto_request[10], button_pressed[11],
	// link_ok[12], derivative_gain[20:13], take_snapshot[21], zero fill
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// valve_code[11:0], extend_angle[19:12], retract_angle[27:20],
	// control_active[28], zero fill
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int VW = vpd_pkg::VALVE_W;
	localparam int MW = vpd_pkg::MUL_W;
	localparam int PW = vpd_pkg::PROD_W;
	localparam int IW = vpd_pkg::INTEG_W;

	vpd_pkg::vpd_state_t state_q, state_d;

	logic [7:0]    kp_q;
	logic [4:0]    ki_q;
	logic [7:0]    end_q;
	logic [VW-1:0] rdb_q;
	logic [VW-1:0] edb_q;
	logic [1:0]    kind_q;

	logic signed [8:0]    cur_err_q;
	logic signed [8:0]    prev_err_q;
	logic signed [IW-1:0] integ_q;
	logic [7:0]           held_ext_q;
	logic [7:0]           held_ret_q;

	logic [1:0]  dir_q;
	logic [7:0]  amt_q;
	logic [7:0]  kd_q;
	logic        snap_q;
	logic        act_q;

	logic signed [18:0]   p_q;
	logic signed [18:0]   d_q;
	logic signed [12:0]   total_q;
	logic [VW-1:0]        code_q;
	logic [7:0]           ext_q;
	logic [7:0]           ret_q;

	logic          m_valid_q;
	logic [VW-1:0] out_code_q;
	logic [7:0]    out_ext_q;
	logic [7:0]    out_ret_q;
	logic          out_act_q;

	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	vpd_pkg::vpd_div_req_t div_req;
	logic                 div_done;
	logic signed [vpd_pkg::QUOT_W:0] quot;

	logic                 accept;
	logic                 engaged_in;
	logic                 out_free;
	logic signed [8:0]    e;
	logic [VW-1:0]        lo;
	logic [VW-1:0]        hi;
	logic signed [5:0]    db;
	logic                 in_band;
	logic signed [IW:0]   integ_raw;
	logic signed [IW-1:0] integ_new;
	logic signed [25:0]   sum_raw;
	logic signed [12:0]   total_c;
	logic signed [16:0]   half;
	logic signed [15:0]   code_raw;
	logic [VW-1:0]        code_c;
	logic                 small_cut;
	logic signed [12:0]   ext_raw;
	logic signed [12:0]   ret_raw;
	logic [7:0]           ext_c;
	logic [7:0]           ret_c;

	assign accept     = s_tvalid && s_tready;
	assign engaged_in = s_tdata[10] && s_tdata[11] && s_tdata[12]
	                    && (s_tdata[1:0] != vpd_pkg::DIR_NONE);
	assign out_free   = !m_valid_q || m_tready;
	assign e          = (dir_q == vpd_pkg::DIR_RAISE) ? $signed({1'b0, amt_q})
	                                                  : -$signed({1'b0, amt_q});
	assign lo         = (kind_q == vpd_pkg::KIND_NARROW) ? vpd_pkg::LO_NARROW : vpd_pkg::LO_STD;
	assign hi         = (kind_q == vpd_pkg::KIND_NARROW) ? vpd_pkg::HI_NARROW : vpd_pkg::HI_STD;
	assign db         = $signed({1'b0, ki_q});
	assign in_band    = (10'(e) > -10'(db)) && (10'(e) < 10'(db));
	assign small_cut  = amt_q < 8'(ki_q);

	always_comb begin
		integ_raw = (IW+1)'(integ_q) + (IW+1)'(prod);
		if (!in_band) begin
			integ_new = '0;
		end else if (integ_raw > $signed((IW+1)'({1'b0, {(IW-1){1'b1}}}))) begin
			integ_new = {1'b0, {(IW-1){1'b1}}};
		end else if (integ_raw < -$signed((IW+1)'({1'b1, {(IW-1){1'b0}}}) >>> 0)
		             && integ_raw < $signed({2'b11, {(IW-1){1'b0}}})) begin
			integ_new = {1'b1, {(IW-1){1'b0}}};
		end else begin
			integ_new = IW'(integ_raw);
		end
		sum_raw = 26'(p_q) + 26'(d_q) + 26'(integ_new);
		if (sum_raw > 26'sd2048) begin
			total_c = 13'(vpd_pkg::PID_LIMIT);
		end else if (sum_raw < -26'sd2048) begin
			total_c = -13'(vpd_pkg::PID_LIMIT);
		end else begin
			total_c = 13'(sum_raw);
		end
	end

	always_comb begin
		half = vpd_pkg::sdiv2048(prod);
		if (dir_q == vpd_pkg::DIR_LOWER) begin
			code_raw = $signed(16'({4'b0, rdb_q})) - 16'(half);
		end else if (dir_q == vpd_pkg::DIR_RAISE) begin
			code_raw = $signed(16'({4'b0, edb_q})) + 16'(half);
		end else begin
			code_raw = $signed(16'({4'b0, vpd_pkg::VALVE_MID}));
		end
		if (code_raw < $signed(16'({4'b0, lo}))) begin
			code_c = lo;
		end else if (code_raw > $signed(16'({4'b0, hi}))) begin
			code_c = hi;
		end else begin
			code_c = VW'(code_raw);
		end
	end

	always_comb begin
		ext_raw = 13'(quot) + 13'sd180;
		ret_raw = 13'(quot) + $signed(13'({5'b0, end_q}));
		if (ext_raw < 13'sd0) begin
			ext_c = '0;
		end else if (ext_raw > 13'sd180) begin
			ext_c = vpd_pkg::PARK_ANGLE;
		end else begin
			ext_c = 8'(ext_raw);
		end
		if (ret_raw < 13'sd0) begin
			ret_c = '0;
		end else if (ret_raw > 13'sd180) begin
			ret_c = vpd_pkg::PARK_ANGLE;
		end else begin
			ret_c = 8'(ret_raw);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vpd_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = engaged_in ? vpd_pkg::ST_MUL_P : vpd_pkg::ST_DONE;
				end
			end
			vpd_pkg::ST_MUL_P:    state_d = vpd_pkg::ST_MUL_D;
			vpd_pkg::ST_MUL_D:    state_d = vpd_pkg::ST_MUL_I;
			vpd_pkg::ST_MUL_I:    state_d = vpd_pkg::ST_SUM;
			vpd_pkg::ST_SUM:      state_d = vpd_pkg::ST_MUL_MAP;
			vpd_pkg::ST_MUL_MAP:  state_d = vpd_pkg::ST_CODE;
			vpd_pkg::ST_CODE: begin
				state_d = small_cut ? vpd_pkg::ST_DONE : vpd_pkg::ST_MUL_EXT;
			end
			vpd_pkg::ST_MUL_EXT:  state_d = vpd_pkg::ST_DIV_EXT;
			vpd_pkg::ST_DIV_EXT:  state_d = vpd_pkg::ST_WAIT_EXT;
			vpd_pkg::ST_WAIT_EXT: begin
				if (div_done) begin
					state_d = vpd_pkg::ST_MUL_RET;
				end
			end
			vpd_pkg::ST_MUL_RET:  state_d = vpd_pkg::ST_DIV_RET;
			vpd_pkg::ST_DIV_RET:  state_d = vpd_pkg::ST_WAIT_RET;
			vpd_pkg::ST_WAIT_RET: begin
				if (div_done) begin
					state_d = vpd_pkg::ST_DONE;
				end
			end
			vpd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = vpd_pkg::ST_IDLE;
				end
			end
			default: state_d = vpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		div_req.num = prod;
		div_req.den = vpd_pkg::DEN_W'(hi - vpd_pkg::VALVE_MID);
		case (state_q)
			vpd_pkg::ST_MUL_P: begin
				mul_a = MW'(e);
				mul_b = MW'($signed({1'b0, kp_q}));
			end
			vpd_pkg::ST_MUL_D: begin
				mul_a = MW'($signed({1'b0, kd_q}));
				mul_b = MW'(10'(e) - 10'(prev_err_q));
			end
			vpd_pkg::ST_MUL_I: begin
				mul_a = MW'(db);
				mul_b = MW'(e);
			end
			vpd_pkg::ST_MUL_MAP: begin
				mul_a = MW'(total_q);
				mul_b = (dir_q == vpd_pkg::DIR_LOWER)
				        ? MW'($signed({1'b0, lo}) - $signed({1'b0, rdb_q}))
				        : MW'($signed({1'b0, hi}) - $signed({1'b0, edb_q}));
			end
			vpd_pkg::ST_MUL_EXT: begin
				mul_a = MW'($signed({1'b0, code_q}) - $signed({1'b0, vpd_pkg::VALVE_MID}));
				mul_b = MW'($signed({2'b0, end_q}) - $signed({2'b0, vpd_pkg::PARK_ANGLE}));
			end
			vpd_pkg::ST_DIV_EXT: begin
				div_req.start = 1'b1;
			end
			vpd_pkg::ST_MUL_RET: begin
				mul_a = MW'($signed({1'b0, code_q}) - $signed({1'b0, lo}));
				mul_b = MW'($signed({2'b0, vpd_pkg::PARK_ANGLE}) - $signed({2'b0, end_q}));
			end
			vpd_pkg::ST_DIV_RET: begin
				div_req.start = 1'b1;
				div_req.den   = vpd_pkg::DEN_W'(vpd_pkg::VALVE_MID - lo);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vpd_pkg::ST_IDLE;
			kp_q       <= 8'd45;
			ki_q       <= 5'd0;
			end_q      <= 8'd160;
			rdb_q      <= 12'd1845;
			edb_q      <= 12'd2250;
			kind_q     <= 2'd0;
			cur_err_q  <= '0;
			prev_err_q <= '0;
			integ_q    <= '0;
			held_ext_q <= vpd_pkg::PARK_ANGLE;
			held_ret_q <= vpd_pkg::PARK_ANGLE;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					vpd_pkg::REG_KP:        kp_q   <= cfg_data[7:0];
					vpd_pkg::REG_KI:        ki_q   <= cfg_data[4:0];
					vpd_pkg::REG_END_ANGLE: end_q  <= cfg_data[7:0];
					vpd_pkg::REG_RET_DB:    rdb_q  <= cfg_data;
					vpd_pkg::REG_EXT_DB:    edb_q  <= cfg_data;
					vpd_pkg::REG_KIND:      kind_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
			if (accept && !engaged_in) begin
				held_ext_q <= vpd_pkg::PARK_ANGLE;
				held_ret_q <= vpd_pkg::PARK_ANGLE;
			end
			if (state_q == vpd_pkg::ST_SUM) begin
				integ_q   <= integ_new;
				cur_err_q <= e;
			end
			if (state_q == vpd_pkg::ST_WAIT_RET && div_done) begin
				held_ext_q <= ext_q;
				held_ret_q <= ret_c;
			end
			if (state_q == vpd_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
				if (snap_q) begin
					prev_err_q <= cur_err_q;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q  <= s_tdata[1:0];
			amt_q  <= s_tdata[9:2];
			kd_q   <= s_tdata[20:13];
			snap_q <= s_tdata[21];
			act_q  <= engaged_in;
			code_q <= vpd_pkg::VALVE_MID;
			ext_q  <= vpd_pkg::PARK_ANGLE;
			ret_q  <= vpd_pkg::PARK_ANGLE;
		end
		case (state_q)
			vpd_pkg::ST_MUL_D: p_q <= 19'(prod);
			vpd_pkg::ST_MUL_I: d_q <= 19'(prod);
			vpd_pkg::ST_SUM:   total_q <= total_c;
			vpd_pkg::ST_CODE: begin
				if (small_cut) begin
					code_q <= vpd_pkg::VALVE_MID;
					ext_q  <= held_ext_q;
					ret_q  <= held_ret_q;
				end else begin
					code_q <= code_c;
				end
			end
			vpd_pkg::ST_WAIT_EXT: begin
				if (div_done) begin
					ext_q <= ext_c;
				end
			end
			vpd_pkg::ST_WAIT_RET: begin
				if (div_done) begin
					ret_q <= ret_c;
				end
			end
			vpd_pkg::ST_DONE: begin
				if (out_free) begin
					out_code_q <= code_q;
					out_ext_q  <= ext_q;
					out_ret_q  <= ret_q;
					out_act_q  <= act_q;
				end
			end
			default: begin
			end
		endcase
	end

	vpd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	vpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	assign s_tready = (state_q == vpd_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b0, out_act_q, out_ret_q, out_ext_q, out_code_q};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != vpd_pkg::ST_IDLE)
		else $error("sequencer stayed idle after a request");
	a_park_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !out_act_q |-> out_code_q == vpd_pkg::VALVE_MID
		&& out_ext_q == vpd_pkg::PARK_ANGLE && out_ret_q == vpd_pkg::PARK_ANGLE)
		else $error("disengaged result not parked");
	a_code_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_act_q |-> out_code_q >= vpd_pkg::LO_STD
		&& out_code_q <= vpd_pkg::HI_STD)
		else $error("valve code outside limits");
	a_angles_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> out_ext_q <= vpd_pkg::PARK_ANGLE && out_ret_q <= vpd_pkg::PARK_ANGLE)
		else $error("servo angle out of range");

endmodule

// ===== hdl/vpd_mul.sv =====
// Shared signed multiplier with a registered product.
module vpd_mul (
	input  logic                              clk,
	input  logic signed [vpd_pkg::MUL_W-1:0]  a,
	input  logic signed [vpd_pkg::MUL_W-1:0]  b,
	output logic signed [vpd_pkg::PROD_W-1:0] prod
);

	logic signed [vpd_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== hdl/vpd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
module vpd_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vpd_pkg::vpd_div_req_t              req,
	output logic                               done,
	output logic signed [vpd_pkg::QUOT_W:0]    quot
);

	localparam int SH_W = vpd_pkg::DEN_W + vpd_pkg::QUOT_W - 1;

	logic                              busy_q;
	logic                              done_q;
	logic [3:0]                        cnt_q;
	logic                              neg_q;
	logic [vpd_pkg::PROD_W-1:0]        rem_q;
	logic [SH_W-1:0]                   den_q;
	logic [vpd_pkg::QUOT_W-1:0]        quot_q;
	logic                              fits;

	assign fits = rem_q >= vpd_pkg::PROD_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(vpd_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q  <= req.num[vpd_pkg::PROD_W-1];
			rem_q  <= req.num[vpd_pkg::PROD_W-1] ? vpd_pkg::PROD_W'(-req.num)
			                                     : vpd_pkg::PROD_W'(req.num);
			den_q  <= SH_W'(req.den) << (vpd_pkg::QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - vpd_pkg::PROD_W'(den_q);
			end
			quot_q <= {quot_q[vpd_pkg::QUOT_W-2:0], fits};
			den_q  <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("divider finished without running");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done)
		else $error("divider busy and done together");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < 4'(vpd_pkg::QUOT_W))
		else $error("divider counter out of range");

endmodule

// ===== tb/sv/valve_pid_drive_top_test.sv =====
// Self-checking testbench for the valve PID drive: predicts every result and compares it.
`timescale 1ns / 1ps
module valve_pid_drive_top_test;

	typedef struct packed {
		logic       snap;
		logic [7:0] kd;
		logic       link;
		logic       button;
		logic       auto_req;
		logic [7:0] amount;
		logic [1:0] dir;
	} tick_t;

	typedef struct packed {
		logic       active;
		logic [7:0] ret_angle;
		logic [7:0] ext_angle;
		logic [11:0] code;
	} drive_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	valve_pid_drive_top uut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Predictor state and registers.
	int kp, ki, end_angle, ret_db, ext_db, kind;
	longint cur_err, prev_err, integ, held_ext, held_ret;

	tick_t tick_queue[$];
	drive_t drive_queue[$];
	int mismatches = 0;
	int results_seen = 0;
	int engaged_seen = 0;
	bit quiet_in = 0;
	bit quiet_out = 0;
	bit sender_pause = 0;
	int hold_cycles = 0;
	bit s_tready_seen = 0;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic drive_t predict_drive(tick_t t);
		drive_t r;
		bit engaged;
		longint lo, hi, e, p, d, total, code, imax, ea, ra;
		engaged = t.auto_req && t.button && t.link && t.dir != vpd_pkg::DIR_NONE;
		code = 2048;
		ea = 180;
		ra = 180;
		if (engaged) begin
			lo = (kind == vpd_pkg::KIND_NARROW) ? 1064 : 450;
			hi = (kind == vpd_pkg::KIND_NARROW) ? 3031 : 3645;
			e = (t.dir == vpd_pkg::DIR_RAISE) ? longint'(t.amount) : -longint'(t.amount);
			cur_err = e;
			p = kp * e;
			d = longint'(t.kd) * (e - prev_err);
			imax = (longint'(1) << 23) - 1;
			if (-ki < e && e < ki)
				integ = clip(integ + ki * e, -imax - 1, imax);
			else
				integ = 0;
			total = clip(p + integ + d, -2048, 2048);
			if (t.dir == vpd_pkg::DIR_LOWER)
				code = total * (lo - ret_db) / (-2048) + ret_db;
			else if (t.dir == vpd_pkg::DIR_RAISE)
				code = total * (hi - ext_db) / 2048 + ext_db;
			code = clip(code, lo, hi);
			if (t.amount < ki) begin
				code = 2048;
				ea = held_ext;
				ra = held_ret;
			end else begin
				ea = clip((code - 2048) * (end_angle - 180) / (hi - 2048) + 180, 0, 180);
				ra = clip((code - lo) * (180 - end_angle) / (2048 - lo) + end_angle, 0, 180);
				held_ext = ea;
				held_ret = ra;
			end
		end else begin
			held_ext = 180;
			held_ret = 180;
		end
		if (t.snap)
			prev_err = cur_err;
		r.code = code[11:0];
		r.ext_angle = ea[7:0];
		r.ret_angle = ra[7:0];
		r.active = engaged;
		return r;
	endfunction

	// Driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready_seen) begin
				if (tick_queue.size() && !sender_pause && (quiet_in || $urandom_range(99) >= 30)) begin
					s_tdata <= {2'b00, tick_queue.pop_front()};
				end else begin
					s_tvalid <= 0;
				end
			end else if (!s_tvalid) begin
				if (tick_queue.size() && !sender_pause && (quiet_in || $urandom_range(99) >= 30)) begin
					s_tdata <= {2'b00, tick_queue.pop_front()};
					s_tvalid <= 1;
				end
			end
			if (hold_cycles > 0)
				m_tready <= 0;
			else
				m_tready <= quiet_out || $urandom_range(99) >= 30;
		end
	end

	// Receiver hold-off counter.
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// Monitor.
	always @(posedge clk) begin
		drive_t got, want;
		s_tready_seen <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			drive_queue.push_back(predict_drive(tick_t'(s_tdata[21:0])));
		if (m_tvalid && m_tready) begin
			got = drive_t'(m_tdata[28:0]);
			results_seen++;
			if (got.active)
				engaged_seen++;
			if (drive_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %h", got);
			end else begin
				want = drive_queue.pop_front();
				if (got.code !== want.code || got.ext_angle !== want.ext_angle ||
						got.ret_angle !== want.ret_angle || got.active !== want.active) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: code %0d/%0d ext %0d/%0d ret %0d/%0d act %0d/%0d",
							want.code, got.code, want.ext_angle, got.ext_angle,
							want.ret_angle, got.ret_angle, want.active, got.active);
				end
			end
		end
	end

	task automatic write_reg(vpd_pkg::vpd_reg_t idx, int val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[11:0];
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			vpd_pkg::REG_KP: kp = val & 8'hFF;
			vpd_pkg::REG_KI: ki = val & 5'h1F;
			vpd_pkg::REG_END_ANGLE: end_angle = val & 8'hFF;
			vpd_pkg::REG_RET_DB: ret_db = val & 12'hFFF;
			vpd_pkg::REG_EXT_DB: ext_db = val & 12'hFFF;
			vpd_pkg::REG_KIND: kind = val & 2'h3;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (tick_queue.size() || s_tvalid || drive_queue.size())
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic tick_t rand_tick(bit engage_bias);
		tick_t t;
		t = 22'($urandom);
		if (engage_bias && $urandom_range(9) < 8) begin
			t.auto_req = 1;
			t.button = 1;
			t.link = 1;
			if (t.dir == vpd_pkg::DIR_NONE && $urandom_range(1))
				t.dir = vpd_pkg::DIR_RAISE;
		end
		if ($urandom_range(3) == 0)
			t.amount = 8'($urandom_range(30));
		return t;
	endfunction

	task automatic queue_tick(logic [1:0] dir, int amount, bit en, int kd, bit snap);
		tick_t t;
		t.dir = dir;
		t.amount = 8'(amount);
		t.auto_req = en;
		t.button = en;
		t.link = en;
		t.kd = 8'(kd);
		t.snap = snap;
		tick_queue.push_back(t);
	endtask

	initial begin
		int settings[6][6];
		tick_t t;
		kp = 45; ki = 0; end_angle = 160; ret_db = 1845; ext_db = 2250; kind = 0;
		cur_err = 0; prev_err = 0; integ = 0; held_ext = 180; held_ret = 180;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: every direction, extremes, small cuts, disengage paths.
		write_reg(vpd_pkg::REG_KI, 5);
		queue_tick(vpd_pkg::DIR_RAISE, 0, 1, 0, 1);
		queue_tick(vpd_pkg::DIR_RAISE, 255, 1, 255, 1);
		queue_tick(vpd_pkg::DIR_LOWER, 255, 1, 255, 1);
		queue_tick(vpd_pkg::DIR_HOLD, 100, 1, 10, 0);
		queue_tick(vpd_pkg::DIR_NONE, 50, 1, 0, 0);
		queue_tick(vpd_pkg::DIR_RAISE, 3, 1, 0, 1);
		queue_tick(vpd_pkg::DIR_LOWER, 2, 1, 0, 1);
		queue_tick(vpd_pkg::DIR_RAISE, 4, 1, 1, 0);
		queue_tick(vpd_pkg::DIR_RAISE, 200, 0, 0, 0);
		t = tick_t'(22'h3FFFFF);
		tick_queue.push_back(t);
		queue_tick(vpd_pkg::DIR_RAISE, 20, 1, 0, 1);
		queue_tick(vpd_pkg::DIR_LOWER, 1, 1, 128, 1);
		for (int i = 0; i < 3; i++) begin
			t = '0; t.auto_req = i != 0; t.button = i != 1; t.link = i != 2; t.amount = 90;
			tick_queue.push_back(t);
		end
		drain();

		settings = '{'{45, 0, 160, 1845, 2250, 0},
			'{255, 25, 0, 2048, 2048, 2},
			'{0, 31, 180, 0, 4095, 1},
			'{1, 24, 255, 2000, 2100, 3},
			'{128, 12, 90, 1500, 2600, 2},
			'{200, 7, 20, 1024, 3000, 0}};
		for (int s = 0; s < 6; s++) begin
			write_reg(vpd_pkg::REG_KP, settings[s][0]);
			write_reg(vpd_pkg::REG_KI, settings[s][1]);
			write_reg(vpd_pkg::REG_END_ANGLE, settings[s][2]);
			write_reg(vpd_pkg::REG_RET_DB, settings[s][3]);
			write_reg(vpd_pkg::REG_EXT_DB, settings[s][4]);
			write_reg(vpd_pkg::REG_KIND, settings[s][5]);
			@(negedge clk);
			cfg_we <= 1; cfg_index <= 3'd7; cfg_data <= 12'hFFF;
			@(negedge clk);
			cfg_we <= 0;
			quiet_in = (s == 2);
			quiet_out = (s == 2);
			for (int i = 0; i < 220; i++)
				tick_queue.push_back(rand_tick(1));
			if (s == 3)
				hold_cycles = 400;
			if (s == 4) begin
				// Halfway through, the sender pauses until every request sent so far has its result.
				while (tick_queue.size() > 110)
					@(posedge clk);
				sender_pause = 1;
				while (s_tvalid || drive_queue.size())
					@(posedge clk);
				repeat (20) @(posedge clk);
				sender_pause = 0;
			end
			drain();
		end

		for (int i = 0; i < 20; i++)
			tick_queue.push_back(rand_tick(0));
		drain();

		$display("Covered %0d results, %0d engaged, over six register settings.",
			results_seen, engaged_seen);
		if (mismatches == 0 && drive_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
